@@ design/hfmr_pkg.sv @@
// Package of shared constants, types and a helper function for the hole-filling block.
`default_nettype none

package hfmr_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int WD_W       = $clog2(MAX_WIDTH + 1);
    localparam int HT_W       = $clog2(MAX_HEIGHT + 1);
    localparam int X_W        = $clog2(MAX_WIDTH);
    localparam int Y_W        = $clog2(MAX_HEIGHT);
    localparam int CFG_W      = 10;
    localparam int PIX_W      = 8;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_READ = 1'b1;

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        SW_INIT,
        SW_FWD,
        SW_BWD
    } hfmr_sweep_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT_RD,
        ST_INIT_WR,
        ST_FWD_RD,
        ST_FWD_WR,
        ST_BWD_RD,
        ST_BWD_WR,
        ST_OUT_RD,
        ST_OUT_WR
    } hfmr_state_t;

    typedef struct packed {
        logic        load;
        logic        out_issue;
        logic        out_take;
        logic        pix_calc;
        logic        seek_first;
        logic        seek_last;
        logic        clr_grew;
        logic        fill_finish;
        hfmr_sweep_t sweep;
    } hfmr_cmd_t;

    typedef struct packed {
        logic fill_done;
        logic sweep_end;
        logic grew;
    } hfmr_stat_t;

    // Out-of-range dimensions: zero is taken as one, large values saturate.
    function automatic int clamp_dim(input int v, input int maxv);
        int r;
        r = v;
        if (v < 1) r = 1;
        else if (v > maxv) r = maxv;
        return r;
    endfunction

endpackage

`default_nettype wire

@@ design/hfmr_ctrl.sv @@
// Sequencer for loading, the reconstruction sweeps and result reads.
`default_nettype none

module hfmr_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_fire,
    input  wire logic               command,
    input  wire hfmr_pkg::hfmr_stat_t stat,
    output hfmr_pkg::hfmr_cmd_t     cmd,
    output logic                    idle
);

    hfmr_pkg::hfmr_state_t state_reg;
    hfmr_pkg::hfmr_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hfmr_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hfmr_pkg::ST_IDLE:
            begin
                if (in_fire && command == hfmr_pkg::CMD_READ)
                begin
                    state_next = stat.fill_done ? hfmr_pkg::ST_OUT_RD : hfmr_pkg::ST_INIT_RD;
                end
            end
            hfmr_pkg::ST_INIT_RD: state_next = hfmr_pkg::ST_INIT_WR;
            hfmr_pkg::ST_INIT_WR:
                state_next = stat.sweep_end ? hfmr_pkg::ST_FWD_RD : hfmr_pkg::ST_INIT_RD;
            hfmr_pkg::ST_FWD_RD:  state_next = hfmr_pkg::ST_FWD_WR;
            hfmr_pkg::ST_FWD_WR:
                state_next = stat.sweep_end ? hfmr_pkg::ST_BWD_RD : hfmr_pkg::ST_FWD_RD;
            hfmr_pkg::ST_BWD_RD:  state_next = hfmr_pkg::ST_BWD_WR;
            hfmr_pkg::ST_BWD_WR:
            begin
                if (!stat.sweep_end)
                    state_next = hfmr_pkg::ST_BWD_RD;
                else if (stat.grew)
                    state_next = hfmr_pkg::ST_FWD_RD;
                else
                    state_next = hfmr_pkg::ST_OUT_RD;
            end
            hfmr_pkg::ST_OUT_RD:  state_next = hfmr_pkg::ST_OUT_WR;
            hfmr_pkg::ST_OUT_WR:  state_next = hfmr_pkg::ST_IDLE;
            default:              state_next = hfmr_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        cmd.sweep = hfmr_pkg::SW_INIT;
        idle = 1'b0;
        unique case (state_reg)
            hfmr_pkg::ST_IDLE:
            begin
                idle = 1'b1;
                if (in_fire && command == hfmr_pkg::CMD_LOAD)
                    cmd.load = 1'b1;
                if (in_fire && command == hfmr_pkg::CMD_READ && !stat.fill_done)
                    cmd.seek_first = 1'b1;
            end
            hfmr_pkg::ST_INIT_RD: cmd.sweep = hfmr_pkg::SW_INIT;
            hfmr_pkg::ST_INIT_WR:
            begin
                cmd.sweep    = hfmr_pkg::SW_INIT;
                cmd.pix_calc = 1'b1;
                if (stat.sweep_end)
                begin
                    cmd.seek_first = 1'b1;
                    cmd.clr_grew   = 1'b1;
                end
            end
            hfmr_pkg::ST_FWD_RD: cmd.sweep = hfmr_pkg::SW_FWD;
            hfmr_pkg::ST_FWD_WR:
            begin
                cmd.sweep    = hfmr_pkg::SW_FWD;
                cmd.pix_calc = 1'b1;
                if (stat.sweep_end)
                    cmd.seek_last = 1'b1;
            end
            hfmr_pkg::ST_BWD_RD: cmd.sweep = hfmr_pkg::SW_BWD;
            hfmr_pkg::ST_BWD_WR:
            begin
                cmd.sweep    = hfmr_pkg::SW_BWD;
                cmd.pix_calc = 1'b1;
                if (stat.sweep_end && stat.grew)
                begin
                    cmd.seek_first = 1'b1;
                    cmd.clr_grew   = 1'b1;
                end
                if (stat.sweep_end && !stat.grew)
                    cmd.fill_finish = 1'b1;
            end
            hfmr_pkg::ST_OUT_RD: cmd.out_issue = 1'b1;
            hfmr_pkg::ST_OUT_WR: cmd.out_take  = 1'b1;
            default: idle = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

@@ design/hfmr_dp.sv @@
// Datapath with the image and marker memories, scan counters and the dilation step.
`default_nettype none

module hfmr_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire hfmr_pkg::hfmr_cmd_t               cmd,
    input  wire logic                              new_frame,
    input  wire logic [hfmr_pkg::CFG_W-1:0]        width_used,
    input  wire logic [hfmr_pkg::CFG_W-1:0]        height_used,
    input  wire logic [hfmr_pkg::PIX_W-1:0]        pixel_in,
    output hfmr_pkg::hfmr_stat_t                   stat,
    output logic [hfmr_pkg::PIX_W-1:0]             pixel_out,
    output logic                                   last_pixel
);

    localparam int AW = hfmr_pkg::ADDR_W;
    localparam int CW = hfmr_pkg::CNT_W;
    localparam int PW = hfmr_pkg::PIX_W;

    logic [PW-1:0] image_mem  [hfmr_pkg::DEPTH];
    logic [PW-1:0] marker_mem [hfmr_pkg::DEPTH];

    logic [hfmr_pkg::WD_W-1:0] fw;
    logic [hfmr_pkg::HT_W-1:0] fh;

    logic [CW-1:0]            n_reg;
    logic [hfmr_pkg::X_W-1:0] x_reg, x_next;
    logic [hfmr_pkg::Y_W-1:0] y_reg, y_next;
    logic [AW-1:0]            p_reg, p_next;
    logic [PW-1:0]            prev_reg;
    logic                     grew_reg;
    logic                     fill_done_reg;
    logic [CW-1:0]            load_pos_reg;
    logic [CW-1:0]            rp_reg;
    logic [AW-1:0]            rpa_reg;
    logic [PW-1:0]            pixel_out_reg;
    logic                     last_pixel_reg;

    logic [PW-1:0] img_q, mk_a_q, mk_b_q;
    logic [AW-1:0] mk_a_addr, mk_b_addr;
    logic [AW-1:0] fw_a;

    logic          x_first, x_last, y_first, y_last;
    logic [PW-1:0] lim, cand_h, cand_v, new_val;
    logic          has_h, has_v, pix_grow;
    logic [CW-1:0] load_at, rp_wrap;
    logic          out_last;

    assign fw   = hfmr_pkg::WD_W'(hfmr_pkg::clamp_dim(int'(width_used), hfmr_pkg::MAX_WIDTH));
    assign fh   = hfmr_pkg::HT_W'(hfmr_pkg::clamp_dim(int'(height_used), hfmr_pkg::MAX_HEIGHT));
    assign fw_a = AW'(fw);

    assign x_first = (x_reg == '0);
    assign y_first = (y_reg == '0);
    assign x_last  = (hfmr_pkg::WD_W'(x_reg) == fw - hfmr_pkg::WD_W'(1));
    assign y_last  = (hfmr_pkg::HT_W'(y_reg) == fh - hfmr_pkg::HT_W'(1));

    // Port A reads the pixel itself (or the result pixel), port B the vertical neighbour.
    assign mk_a_addr = cmd.out_issue ? rp_wrap[AW-1:0] : p_reg;
    assign mk_b_addr = (cmd.sweep == hfmr_pkg::SW_BWD) ? p_reg + fw_a : p_reg - fw_a;
    assign rp_wrap   = (rp_reg >= n_reg) ? '0 : rp_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load && load_at < n_reg)
            image_mem[load_at[AW-1:0]] <= pixel_in;
        img_q <= image_mem[p_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.pix_calc)
            marker_mem[p_reg] <= new_val;
        mk_a_q <= marker_mem[mk_a_addr];
        mk_b_q <= marker_mem[mk_b_addr];
    end

    // One geodesic dilation step, limited by the mask; the init sweep seeds the border.
    always_comb
    begin
        lim    = ~img_q;
        cand_h = (prev_reg < lim) ? prev_reg : lim;
        cand_v = (mk_b_q < lim) ? mk_b_q : lim;
        has_h  = 1'b0;
        has_v  = 1'b0;
        unique case (cmd.sweep)
            hfmr_pkg::SW_FWD:
            begin
                has_h = !x_first;
                has_v = !y_first;
            end
            hfmr_pkg::SW_BWD:
            begin
                has_h = !x_last;
                has_v = !y_last;
            end
            default:
            begin
                has_h = 1'b0;
                has_v = 1'b0;
            end
        endcase
        new_val = mk_a_q;
        if (has_h && cand_h > new_val)
            new_val = cand_h;
        if (has_v && cand_v > new_val)
            new_val = cand_v;
        if (cmd.sweep == hfmr_pkg::SW_INIT)
            new_val = (x_first || y_first || x_last || y_last) ? lim : '0;
        pix_grow = (cmd.sweep != hfmr_pkg::SW_INIT) && (new_val != mk_a_q);
    end

    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        p_next = p_reg;
        priority if (cmd.seek_first)
        begin
            x_next = '0;
            y_next = '0;
            p_next = '0;
        end
        else if (cmd.seek_last)
        begin
            x_next = hfmr_pkg::X_W'(fw - hfmr_pkg::WD_W'(1));
            y_next = hfmr_pkg::Y_W'(fh - hfmr_pkg::HT_W'(1));
            p_next = n_reg[AW-1:0] - AW'(1);
        end
        else if (cmd.pix_calc && cmd.sweep == hfmr_pkg::SW_BWD)
        begin
            p_next = p_reg - AW'(1);
            if (x_first)
            begin
                x_next = hfmr_pkg::X_W'(fw - hfmr_pkg::WD_W'(1));
                y_next = y_reg - hfmr_pkg::Y_W'(1);
            end
            else
            begin
                x_next = x_reg - hfmr_pkg::X_W'(1);
            end
        end
        else if (cmd.pix_calc)
        begin
            p_next = p_reg + AW'(1);
            if (x_last)
            begin
                x_next = '0;
                y_next = y_reg + hfmr_pkg::Y_W'(1);
            end
            else
            begin
                x_next = x_reg + hfmr_pkg::X_W'(1);
            end
        end
    end

    assign load_at  = fill_done_reg ? '0 : load_pos_reg;
    assign out_last = (CW'(rpa_reg) == n_reg - CW'(1));

    always_ff @(posedge clk)
    begin
        n_reg <= CW'(fw * fh);
        x_reg <= x_next;
        y_reg <= y_next;
        p_reg <= p_next;
        if (cmd.pix_calc)
            prev_reg <= new_val;
        if (cmd.out_issue)
            rpa_reg <= rp_wrap[AW-1:0];
        if (cmd.out_take)
        begin
            pixel_out_reg  <= ~mk_a_q;
            last_pixel_reg <= out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grew_reg      <= 1'b0;
            fill_done_reg <= 1'b0;
            load_pos_reg  <= '0;
            rp_reg        <= '0;
        end
        else
        begin
            if (cmd.clr_grew)
                grew_reg <= 1'b0;
            else if (cmd.pix_calc && pix_grow)
                grew_reg <= 1'b1;

            priority if (new_frame)
            begin
                load_pos_reg  <= '0;
                rp_reg        <= '0;
                fill_done_reg <= 1'b0;
            end
            else if (cmd.load)
            begin
                load_pos_reg  <= (load_at < n_reg) ? load_at + CW'(1) : load_at;
                if (fill_done_reg)
                    rp_reg <= '0;
                fill_done_reg <= 1'b0;
            end
            else if (cmd.fill_finish)
            begin
                fill_done_reg <= 1'b1;
                rp_reg        <= '0;
            end
            else if (cmd.out_take)
            begin
                if (out_last)
                begin
                    load_pos_reg  <= '0;
                    rp_reg        <= '0;
                    fill_done_reg <= 1'b0;
                end
                else
                begin
                    rp_reg <= CW'(rpa_reg) + CW'(1);
                end
            end
        end
    end

    assign stat.fill_done = fill_done_reg;
    assign stat.sweep_end = (cmd.sweep == hfmr_pkg::SW_BWD) ? (x_first && y_first)
                                                             : (x_last && y_last);
    assign stat.grew      = grew_reg || (cmd.pix_calc && pix_grow);

    assign pixel_out  = pixel_out_reg;
    assign last_pixel = last_pixel_reg;

endmodule

`default_nettype wire

@@ design/hole_fill_morph_reconstruction_top.sv @@
// Top level of the hole-filling block: handshakes, register port and the two submodules.
// Loads stream at one pixel per cycle while in_ready stays high.
// A read after the fill is issued in ST_OUT_RD and taken in ST_OUT_WR before new items are taken.
// The first read of a frame first runs the fill: an init sweep sets up the marker, then
// forward/backward sweep pairs repeat until no pixel grows, with a read and a write state
// per pixel, bounded by the single-ported image memory and the two-read marker memory.
// Reset (rst_n, asynchronous, active low) clears control state; memories hold stale data.
`default_nettype none

module hole_fill_morph_reconstruction_top (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [hfmr_pkg::PADDR_W-1:0]    paddr,
    input  wire logic [hfmr_pkg::PDATA_W-1:0]    pwdata,
    output logic      [hfmr_pkg::PDATA_W-1:0]    prdata,
    output logic                                 pready,
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire logic                            command,
    input  wire logic [hfmr_pkg::PIX_W-1:0]      pixel_in,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [hfmr_pkg::PIX_W-1:0]      pixel_out,
    output logic                                 last_pixel
);

    logic [hfmr_pkg::CFG_W-1:0] width_used_reg;
    logic [hfmr_pkg::CFG_W-1:0] height_used_reg;
    logic                       cfg_busy_reg;
    logic                       out_valid_reg;
    logic                       cfg_we;
    logic                       in_fire;
    logic                       idle;
    hfmr_pkg::hfmr_cmd_t        cmd;
    hfmr_pkg::hfmr_stat_t       stat;

    // Register writes complete in the access phase; pready is tied high.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_used_reg  <= hfmr_pkg::CFG_W'(hfmr_pkg::MAX_WIDTH);
            height_used_reg <= hfmr_pkg::CFG_W'(hfmr_pkg::MAX_HEIGHT);
            cfg_busy_reg    <= 1'b0;
        end
        else
        begin
            cfg_busy_reg <= cfg_we;
            if (cfg_we && paddr[2] == hfmr_pkg::REG_WIDTH)
                width_used_reg <= pwdata[hfmr_pkg::CFG_W-1:0];
            if (cfg_we && paddr[2] == hfmr_pkg::REG_HEIGHT)
                height_used_reg <= pwdata[hfmr_pkg::CFG_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (paddr[2] == hfmr_pkg::REG_WIDTH)
            prdata = hfmr_pkg::PDATA_W'(width_used_reg);
        else
            prdata = hfmr_pkg::PDATA_W'(height_used_reg);
    end

    // An item is taken only while the sequencer is idle and the result register
    // is free or being emptied in the same cycle, so a read never overwrites a
    // result that has not been transferred. The cycle after a register write is
    // skipped so that the frame size product has settled.
    assign in_ready = idle && !cfg_busy_reg && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.out_take)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;

    hfmr_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_fire (in_fire),
        .command (command),
        .stat    (stat),
        .cmd     (cmd),
        .idle    (idle)
    );

    // Any register write starts a new frame; stored pixels are kept.
    hfmr_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .new_frame   (cfg_we),
        .width_used  (width_used_reg),
        .height_used (height_used_reg),
        .pixel_in    (pixel_in),
        .stat        (stat),
        .pixel_out   (pixel_out),
        .last_pixel  (last_pixel)
    );

endmodule

`default_nettype wire
